/* hw/rtl/wavetable_voice_mixer_macros.svh */
// Assertion macros for the voice mixer; ASSERT_OFF removes them.
`ifndef WAVETABLE_VOICE_MIXER_MACROS_SVH
`define WAVETABLE_VOICE_MIXER_MACROS_SVH
`ifndef ASSERT_OFF
`define WVM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WVM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WVM_ASSERT_IMP(name, ante, cons, msg)
`define WVM_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

/* hw/rtl/wvm_pkg.sv */
`timescale 1ns / 1ps
package wvm_pkg;
  localparam logic [2:0] ACT_POOL    = 3'd0;
  localparam logic [2:0] ACT_VOICE   = 3'd1;
  localparam logic [2:0] ACT_LOOP    = 3'd2;
  localparam logic [2:0] ACT_ONESHOT = 3'd3;
  localparam logic [2:0] ACT_RENDER  = 3'd4;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = 51;
  localparam int ACC_W   = 26;
  localparam int SUM_W   = 22;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(22'sh1FFFFF));
    lo = ACC_W'(signed'(22'sh200000));
    if (x > hi) return 22'sh1FFFFF;
    if (x < lo) return 22'sh200000;
    return x[SUM_W-1:0];
  endfunction
endpackage

/* hw/rtl/wvm_mul.sv */
`timescale 1ns / 1ps
module wvm_mul (
  input  logic            clk,
  input  wvm_pkg::mul_a_t a,
  input  wvm_pkg::mul_b_t b,
  output wvm_pkg::mul_p_t p_r
);
  import wvm_pkg::*;

  mul_p_t p_nxt;

  assign p_nxt = MUL_P_W'(a) * MUL_P_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule

/* hw/rtl/wavetable_voice_mixer.sv */
`timescale 1ns / 1ps
// A render word steps each active voice through S_VRD to S_PH, adding the S_MOD
// bit-serial remainder for each voice whose loop wraps more than one span, then
// S_OUT; write words are taken in S_IDLE. One word at a time, as in_stall is high
// outside S_IDLE; the multiplier is shared. Results wait in an output register.
// Reset (synchronous, rst_n low): idle, no result, active_voices = 64, loop flags clear.
`include "wavetable_voice_mixer_macros.svh"
module wavetable_voice_mixer #(
  parameter int VOICES     = 64,
  parameter int POOL_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_action,
  input  logic [11:0]         in_index,
  input  logic signed [15:0]  in_sample_value,
  input  logic [31:0]         in_start_phase,
  input  logic [21:0]         in_step,
  input  logic [15:0]         in_gain_left,
  input  logic [15:0]         in_gain_right,
  input  logic [15:0]         in_envelope,
  input  logic [11:0]         in_region_base,
  input  logic [12:0]         in_loop_start,
  input  logic [12:0]         in_loop_end,
  input  logic [12:0]         in_region_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [21:0]  out_left_sum,
  output logic signed [21:0]  out_right_sum
);
  import wvm_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_VRD   = 13'b0000000000010,
    S_ADDR0 = 13'b0000000000100,
    S_ADDR1 = 13'b0000000001000,
    S_DIFF  = 13'b0000000010000,
    S_INT   = 13'b0000000100000,
    S_ENV   = 13'b0000001000000,
    S_GL    = 13'b0000010000000,
    S_GR    = 13'b0000100000000,
    S_ACCR  = 13'b0001000000000,
    S_PH    = 13'b0010000000000,
    S_MOD   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  // storage
  logic [15:0] pool_mem  [POOL_DEPTH];
  logic [31:0] phase_mem [VOICES];
  logic [21:0] step_mem  [VOICES];
  logic [47:0] gain_mem  [VOICES];
  logic [24:0] reg_mem   [VOICES];
  logic [25:0] loop_mem  [VOICES];
  logic [VOICES-1:0] loop_flag_r, loop_flag_nxt;

  logic [15:0] pool_q_r;
  logic [31:0] ph_q_r;
  logic [21:0] step_q_r;
  logic [47:0] gain_q_r;
  logic [24:0] reg_q_r;
  logic [25:0] loop_q_r;
  logic        lp_q_r;

  state_t state_r, state_nxt;
  logic [6:0]  active_r, active_nxt;
  logic [CW-1:0] vox_r, vox_nxt, n_r, n_nxt;
  logic signed [ACC_W-1:0] acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic signed [15:0] s0_r, s0_nxt;
  logic signed [16:0] smpl_r, smpl_nxt;
  logic signed [32:0] pe_r, pe_nxt;
  logic [32:0] p_r, p_nxt;
  logic [16:0] dvd_r, dvd_nxt;
  logic [15:0] low_r, low_nxt;
  logic [12:0] rem_r, rem_nxt, span_r, span_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic signed [21:0] out_l_r, out_l_nxt, out_r_r, out_r_nxt;

  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t prod_r;

  logic in_acc, voice_ok;
  logic [VW-1:0] wvox, rvox;
  logic [AW-1:0] pool_waddr, pool_raddr, addr0, addr1;
  logic [12:0] len_eff, i0, i1;
  logic [16:0] i_p1;
  logic [15:0] ph_int;
  logic [13:0] sum0, sum1;
  logic [8:0]  act9;
  logic signed [MUL_P_W-1:0] interp_t, scale_t;
  logic signed [ACC_W-1:0] contrib;
  logic [32:0] le16, ls16, span16, len16, p2, q, pfin, pmod;
  logic [13:0] rtry, rnext;
  logic ph_we, go_mod;
  logic [12:0] ls_q, le_q;

  wvm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod_r));

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign voice_ok   = (in_index < 12'(VOICES));
  assign wvox       = in_index[VW-1:0];
  assign rvox       = vox_r[VW-1:0];
  assign pool_waddr = AW'(in_index);

  // address generation from the voice read
  assign ls_q    = loop_q_r[12:0];
  assign le_q    = loop_q_r[25:13];
  assign len_eff = (reg_q_r[24:12] == 13'd0) ? 13'd1 : reg_q_r[24:12];
  assign ph_int  = ph_q_r[31:16];
  assign i_p1    = {1'b0, ph_int} + 17'd1;
  assign i0      = (ph_int >= {3'b0, len_eff}) ? len_eff - 13'd1 : ph_int[12:0];
  assign i1      = (i_p1 >= {4'b0, len_eff}) ? len_eff - 13'd1 : i_p1[12:0];
  assign sum0    = {2'b0, reg_q_r[11:0]} + {1'b0, i0};
  assign sum1    = {2'b0, reg_q_r[11:0]} + {1'b0, i1};
  assign addr0   = AW'(sum0);
  assign addr1   = AW'(sum1);
  assign pool_raddr = (state_r == S_ADDR1) ? addr1 : addr0;

  assign interp_t = (prod_r + MUL_P_W'(32768)) >>> 16;
  assign scale_t  = (prod_r + (MUL_P_W'(1) <<< 29)) >>> 30;
  assign contrib  = ACC_W'(signed'(scale_t[20:0]));

  assign act9  = {2'b0, active_r};
  assign n_nxt = (act9 > 9'(VOICES)) ? CW'(VOICES) : CW'(act9);

  // phase advance
  assign le16   = {4'b0, le_q, 16'b0};
  assign ls16   = {4'b0, ls_q, 16'b0};
  assign span16 = le16 - ls16;
  assign len16  = {4'b0, len_eff, 16'b0};
  assign p2     = p_r - span16;
  assign q      = p2 - ls16;
  always_comb begin
    go_mod = 1'b0;
    pfin   = p_r;
    if (lp_q_r) begin
      if (p_r >= le16) begin
        if (ls_q >= le_q) begin
          pfin = ls16;
        end else if (p2 >= le16) begin
          go_mod = 1'b1;
        end else begin
          pfin = p2;
        end
      end
    end else if (p_r >= len16) begin
      pfin = {4'b0, len_eff - 13'd1, 16'b0};
    end
  end

  // one remainder bit a cycle
  assign rtry  = {rem_r, dvd_r[16]};
  assign rnext = (rtry >= {1'b0, span_r}) ? rtry - {1'b0, span_r} : rtry;
  assign pmod  = ls16 + {4'b0, rnext[12:0], low_r};

  assign ph_we = ((state_r == S_PH) && !go_mod) || ((state_r == S_MOD) && (cnt_r == 5'd1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DIFF: begin
        mul_a = MUL_A_W'(signed'({pool_q_r[15], pool_q_r}) - signed'({s0_r[15], s0_r}));
        mul_b = {2'b0, ph_q_r[15:0]};
      end
      S_ENV: begin
        mul_a = MUL_A_W'(smpl_r);
        mul_b = {2'b0, gain_q_r[47:32]};
      end
      S_GL: begin
        mul_a = prod_r[32:0];
        mul_b = {2'b0, gain_q_r[15:0]};
      end
      S_GR: begin
        mul_a = pe_r;
        mul_b = {2'b0, gain_q_r[31:16]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = cfg_wr_en ? cfg_wr_data : active_r;
    loop_flag_nxt = loop_flag_r;
    vox_nxt       = vox_r;
    acc_l_nxt     = acc_l_r;
    acc_r_nxt     = acc_r_r;
    s0_nxt        = s0_r;
    smpl_nxt      = smpl_r;
    pe_nxt        = pe_r;
    p_nxt         = p_r;
    dvd_nxt       = dvd_r;
    low_nxt       = low_r;
    rem_nxt       = rem_r;
    span_nxt      = span_r;
    cnt_nxt       = cnt_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_action == ACT_LOOP || in_action == ACT_ONESHOT) && voice_ok) begin
            loop_flag_nxt[wvox] = (in_action == ACT_LOOP);
          end
          if (in_action == ACT_RENDER) begin
            acc_l_nxt = '0;
            acc_r_nxt = '0;
            vox_nxt   = '0;
            state_nxt = (n_nxt == '0) ? S_OUT : S_VRD;
          end
        end
      end
      S_VRD:   state_nxt = S_ADDR0;
      S_ADDR0: begin
        p_nxt     = {1'b0, ph_q_r} + {11'b0, step_q_r};
        state_nxt = S_ADDR1;
      end
      S_ADDR1: begin
        s0_nxt    = signed'(pool_q_r);
        state_nxt = S_DIFF;
      end
      S_DIFF:  state_nxt = S_INT;
      S_INT: begin
        smpl_nxt  = 17'(signed'({s0_r[15], s0_r})) + signed'(interp_t[16:0]);
        state_nxt = S_ENV;
      end
      S_ENV:   state_nxt = S_GL;
      S_GL: begin
        pe_nxt    = prod_r[32:0];
        state_nxt = S_GR;
      end
      S_GR: begin
        acc_l_nxt = acc_l_r + contrib;
        state_nxt = S_ACCR;
      end
      S_ACCR: begin
        acc_r_nxt = acc_r_r + contrib;
        state_nxt = S_PH;
      end
      S_PH: begin
        if (go_mod) begin
          dvd_nxt   = q[32:16];
          low_nxt   = q[15:0];
          rem_nxt   = '0;
          span_nxt  = le_q - ls_q;
          cnt_nxt   = 5'd17;
          state_nxt = S_MOD;
        end else if ((vox_r + CW'(1)) == n_r) begin
          state_nxt = S_OUT;
        end else begin
          vox_nxt   = vox_r + CW'(1);
          state_nxt = S_VRD;
        end
      end
      S_MOD: begin
        rem_nxt = rnext[12:0];
        dvd_nxt = {dvd_r[15:0], 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          if ((vox_r + CW'(1)) == n_r) begin
            state_nxt = S_OUT;
          end else begin
            vox_nxt   = vox_r + CW'(1);
            state_nxt = S_VRD;
          end
        end
      end
      S_OUT: begin
        // hold until the previous word has gone
        if (!out_valid_r || !out_stall) begin
          out_l_nxt     = sat_sum(acc_l_r);
          out_r_nxt     = sat_sum(acc_r_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [CW-1:0] n_load;
  assign n_load = (state_r == S_IDLE && in_acc) ? n_nxt : n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 7'd64;
      loop_flag_r <= '0;
      out_valid_r <= 1'b0;
      vox_r       <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      loop_flag_r <= loop_flag_nxt;
      out_valid_r <= out_valid_nxt;
      vox_r       <= vox_nxt;
      n_r         <= n_load;
    end
  end

  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
    s0_r    <= s0_nxt;
    smpl_r  <= smpl_nxt;
    pe_r    <= pe_nxt;
    p_r     <= p_nxt;
    dvd_r   <= dvd_nxt;
    low_r   <= low_nxt;
    rem_r   <= rem_nxt;
    span_r  <= span_nxt;
    cnt_r   <= cnt_nxt;
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_POOL) begin
      pool_mem[pool_waddr] <= in_sample_value;
    end
    pool_q_r <= pool_mem[pool_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_VOICE && voice_ok) begin
      phase_mem[wvox] <= in_start_phase;
    end else if (ph_we) begin
      phase_mem[rvox] <= (state_r == S_MOD) ? pmod[31:0] : pfin[31:0];
    end
    if (in_acc && in_action == ACT_VOICE && voice_ok) begin
      step_mem[wvox] <= in_step;
      gain_mem[wvox] <= {in_envelope, in_gain_right, in_gain_left};
    end
    if (in_acc && (in_action == ACT_LOOP || in_action == ACT_ONESHOT) && voice_ok) begin
      reg_mem[wvox] <= {in_region_length, in_region_base};
    end
    if (in_acc && in_action == ACT_LOOP && voice_ok) begin
      loop_mem[wvox] <= {in_loop_end, in_loop_start};
    end
    ph_q_r   <= phase_mem[rvox];
    step_q_r <= step_mem[rvox];
    gain_q_r <= gain_mem[rvox];
    reg_q_r  <= reg_mem[rvox];
    loop_q_r <= loop_mem[rvox];
    lp_q_r   <= loop_flag_r[rvox];
  end

  assign out_valid     = out_valid_r;
  assign out_left_sum  = out_l_r;
  assign out_right_sum = out_r_r;

  `WVM_ASSERT_IMP(a_vox_in_range, (state_r != S_IDLE && state_r != S_OUT), (vox_r < n_r), "voice counter past active count")
  `WVM_ASSERT_IMP(a_rem_below_span, (state_r == S_MOD), (rem_r < span_r), "loop remainder not below span")
  `WVM_ASSERT_NXT(a_out_load, (state_r == S_OUT && (!out_valid_r || !out_stall)), (out_valid_r && state_r == S_IDLE), "render result not presented")
endmodule
